@@ hdl/bsr_pkg.sv @@
// Shared constants for the Babylonian square root block.
// Used by bsr_csr, bsr_divider and babylonian_square_root; depends on nothing.
`timescale 1ns / 1ps

package bsr_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int MAX_ROUNDS = 32;

   localparam int RAD_W    = 32;
   localparam int ROOT_W   = 24;
   localparam int ROUNDS_W = 6;
   localparam int TOL_W    = 16;
   localparam int APB_W    = 32;
   localparam int ADDR_W   = 2;

   localparam int GUESS_W = RAD_W;
   localparam int NUM_W   = RAD_W + FRAC_BITS;
   localparam int CNT_W   = $clog2(NUM_W + 1);
   localparam int RCNT_W  = $clog2(MAX_ROUNDS + 1);

   localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(655);
   localparam logic [ROOT_W-1:0] ROOT_MAX   = {ROOT_W{1'b1}};
   localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = {ROUNDS_W{1'b1}};

   localparam logic [ADDR_W-1:0] ADDR_TOLERANCE = ADDR_W'(0);

endpackage

@@ hdl/bsr_csr.sv @@
// APB-style register port holding the convergence tolerance.
// Depends on bsr_pkg.
`timescale 1ns / 1ps

module bsr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bsr_pkg::ADDR_W-1:0]    paddr,
   input  logic [bsr_pkg::APB_W-1:0]     pwdata,
   output logic [bsr_pkg::APB_W-1:0]     prdata,
   output logic                          pready,
   output logic [bsr_pkg::TOL_W-1:0]     tolerance
);

   logic [bsr_pkg::TOL_W-1:0] tol_ff;
   logic [bsr_pkg::TOL_W-1:0] tol_in;
   logic                      hit;

   assign hit    = (paddr == bsr_pkg::ADDR_TOLERANCE);
   assign pready = 1'b1;

   always_comb begin
      tol_in = tol_ff;
      if (psel && penable && pwrite && hit) begin
         tol_in = pwdata[bsr_pkg::TOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= bsr_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   assign prdata    = hit ? bsr_pkg::APB_W'(tol_ff) : '0;
   assign tolerance = tol_ff;

endmodule

@@ hdl/bsr_divider.sv @@
// Radix-2 restoring divider that shifts in one dividend bit and one quotient bit per cycle.
// Depends on bsr_pkg.
`timescale 1ns / 1ps

module bsr_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bsr_pkg::NUM_W-1:0]      dividend,
   input  logic [bsr_pkg::GUESS_W-1:0]    divisor,
   output logic                           done,
   output logic [bsr_pkg::NUM_W-1:0]      quotient
);

   localparam int REM_W = bsr_pkg::GUESS_W + 1;

   logic [bsr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        done_ff, done_in;
   logic [bsr_pkg::NUM_W-1:0]   nq_ff, nq_in;
   logic [bsr_pkg::GUESS_W-1:0] rem_ff, rem_in;
   logic [bsr_pkg::GUESS_W-1:0] dv_ff, dv_in;
   logic [REM_W-1:0]            rem_sh;
   logic [REM_W:0]              trial;

   assign rem_sh = {rem_ff, nq_ff[bsr_pkg::NUM_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, dv_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      if (start) begin
         cnt_in = bsr_pkg::CNT_W'(bsr_pkg::NUM_W);
         nq_in  = dividend;
         rem_in = '0;
         dv_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial[REM_W]) begin
            rem_in = rem_sh[bsr_pkg::GUESS_W-1:0];
            nq_in  = {nq_ff[bsr_pkg::NUM_W-2:0], 1'b0};
         end else begin
            rem_in = trial[bsr_pkg::GUESS_W-1:0];
            nq_in  = {nq_ff[bsr_pkg::NUM_W-2:0], 1'b1};
         end
         if (cnt_ff == bsr_pkg::CNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
   end

   assign done     = done_ff;
   assign quotient = nq_ff;

endmodule

@@ hdl/babylonian_square_root.sv @@
// Sequence: a zero radicand is answered straight from idle; otherwise each Newton round runs the
// 48-step bit-serial divider, then the mean state and the check state; up to 32 rounds.
// One request at a time; busy falls as the result strobe rises, so the next request can be
// accepted in that cycle.
// Reset is synchronous and active high; it clears the sequencer and sets tolerance to 655.
// The receiver cannot stall: each result is shown on rsp_valid for exactly one cycle.
// Depends on bsr_pkg, bsr_csr and bsr_divider.
`timescale 1ns / 1ps

module babylonian_square_root (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [bsr_pkg::RAD_W-1:0]        req_radicand,
   output logic                             rsp_valid,
   output logic [bsr_pkg::ROOT_W-1:0]       rsp_root,
   output logic [bsr_pkg::ROUNDS_W-1:0]     rsp_rounds_used,
   output logic                             rsp_cap_hit,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bsr_pkg::ADDR_W-1:0]       paddr,
   input  logic [bsr_pkg::APB_W-1:0]        pwdata,
   output logic [bsr_pkg::APB_W-1:0]        prdata,
   output logic                             pready
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_DIV   = 2'd1;
   localparam logic [1:0] S_MEAN  = 2'd2;
   localparam logic [1:0] S_CHECK = 2'd3;

   localparam int GW = bsr_pkg::GUESS_W;
   localparam int NW = bsr_pkg::NUM_W;

   logic [1:0]                     state_ff, state_in;
   logic [bsr_pkg::RAD_W-1:0]      rad_ff, rad_in;
   logic [GW-1:0]                  guess_ff, guess_in;
   logic [GW-1:0]                  prev_ff, prev_in;
   logic [bsr_pkg::RCNT_W-1:0]     rounds_ff, rounds_in;
   logic                           valid_ff, valid_in;
   logic [bsr_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [bsr_pkg::ROUNDS_W-1:0]   rused_ff, rused_in;
   logic                           cap_ff, cap_in;

   logic [bsr_pkg::TOL_W-1:0]      tolerance;
   logic                           accept;
   logic                           div_start;
   logic                           div_done;
   logic [NW-1:0]                  div_dividend;
   logic [GW-1:0]                  div_divisor;
   logic [NW-1:0]                  quotient;
   logic [GW-1:0]                  guess0;
   logic [NW:0]                    mean_sum;
   logic [GW-1:0]                  mean;
   logic [GW-1:0]                  change;
   logic                           converged;
   logic                           at_cap;

   bsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .tolerance (tolerance)
   );

   bsr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign guess0 = (req_radicand[bsr_pkg::RAD_W-1:1] == '0) ?
                   GW'(1) : GW'(req_radicand >> 1);

   assign mean_sum = (NW+1)'(guess_ff >> 1) + (NW+1)'(quotient >> 1)
                   + (NW+1)'(guess_ff[0] & quotient[0]);
   assign mean     = mean_sum[GW-1:0];

   assign change    = (guess_ff >= prev_ff) ? (guess_ff - prev_ff) : (prev_ff - guess_ff);
   assign converged = (change <= GW'(tolerance));
   assign at_cap    = (rounds_ff == bsr_pkg::RCNT_W'(bsr_pkg::MAX_ROUNDS));

   assign div_dividend = (state_ff == S_IDLE) ?
                         {req_radicand, bsr_pkg::FRAC_BITS'(0)} :
                         {rad_ff, bsr_pkg::FRAC_BITS'(0)};
   assign div_divisor  = (state_ff == S_IDLE) ? guess0 : guess_ff;
   assign div_start    = (accept && (req_radicand != '0)) ||
                         ((state_ff == S_CHECK) && !converged && !at_cap);

   always_comb begin
      state_in  = state_ff;
      rad_in    = rad_ff;
      guess_in  = guess_ff;
      prev_in   = prev_ff;
      rounds_in = rounds_ff;
      valid_in  = 1'b0;
      root_in   = root_ff;
      rused_in  = rused_ff;
      cap_in    = cap_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rad_in    = req_radicand;
               guess_in  = guess0;
               rounds_in = '0;
               if (req_radicand == '0) begin
                  valid_in = 1'b1;
                  root_in  = '0;
                  rused_in = '0;
                  cap_in   = 1'b0;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            prev_in   = guess_ff;
            guess_in  = (mean == '0) ? GW'(1) : mean;
            rounds_in = rounds_ff + 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (converged || at_cap) begin
               state_in = S_IDLE;
               valid_in = 1'b1;
               root_in  = (guess_ff > GW'(bsr_pkg::ROOT_MAX)) ?
                          bsr_pkg::ROOT_MAX : guess_ff[bsr_pkg::ROOT_W-1:0];
               rused_in = (32'(rounds_ff) > 32'(bsr_pkg::ROUNDS_MAX)) ?
                          bsr_pkg::ROUNDS_MAX : bsr_pkg::ROUNDS_W'(rounds_ff);
               cap_in   = !converged;
            end else begin
               state_in = S_DIV;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff    <= rad_in;
      guess_ff  <= guess_in;
      prev_ff   <= prev_in;
      rounds_ff <= rounds_in;
      root_ff   <= root_in;
      rused_ff  <= rused_in;
      cap_ff    <= cap_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_root        = root_ff;
   assign rsp_rounds_used = rused_ff;
   assign rsp_cap_hit     = cap_ff;

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("Divider finished outside the divide state.");

   a_guess_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (guess_ff != '0))
      else $error("Division started with a zero guess.");

   a_cap_rounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cap_hit) |->
         (32'(rsp_rounds_used) == ((bsr_pkg::MAX_ROUNDS > 63) ? 63 : bsr_pkg::MAX_ROUNDS)))
      else $error("Cap flag set without the full number of rounds.");

   a_zero_rounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_rounds_used == '0)) |-> ((rsp_root == '0) && !rsp_cap_hit))
      else $error("Result without rounds must be a zero root.");

   a_result_ends_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && $past(busy) |-> !busy)
      else $error("Result issued while the sequencer is still running.");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for babylonian_square_root: drives Q16.16 radicand requests
// and tolerance writes, predicts each root with a Newton-iteration scoreboard and checks it.
// Depends on bsr_pkg and the babylonian_square_root RTL.
`timescale 1ns / 1ps

typedef struct packed {
   logic [bsr_pkg::ROOT_W-1:0]   root;
   logic [bsr_pkg::ROUNDS_W-1:0] rounds_used;
   logic                         cap_hit;
} root_result_type;

class root_scoreboard;
   logic [bsr_pkg::TOL_W-1:0] tolerance;
   root_result_type           pending_roots[$];
   int unsigned               mismatches;

   function new();
      tolerance   = bsr_pkg::TOL_RESET;
      mismatches  = 0;
   endfunction

   function void set_tolerance(input logic [bsr_pkg::TOL_W-1:0] value);
      tolerance = value;
   endfunction

   function int pending();
      return pending_roots.size();
   endfunction

   function root_result_type predict_root(input logic [bsr_pkg::RAD_W-1:0] radicand);
      logic [63:0]     num;
      logic [63:0]     guess;
      logic [63:0]     prev;
      logic [63:0]     quot;
      logic [63:0]     delta;
      int unsigned     rounds;
      bit              converged;
      root_result_type result;
      result = '0;
      if (radicand == '0) begin
         return result;
      end
      num       = {32'b0, radicand} << bsr_pkg::FRAC_BITS;
      guess     = {33'b0, radicand[bsr_pkg::RAD_W-1:1]};
      if (guess == 64'd0) begin
         guess = 64'd1;
      end
      rounds    = 0;
      converged = 1'b0;
      while (!converged && rounds < bsr_pkg::MAX_ROUNDS) begin
         prev  = guess;
         quot  = num / prev;
         guess = (prev >> 1) + (quot >> 1) + (prev & quot & 64'd1);
         if (guess == 64'd0) begin
            guess = 64'd1;
         end
         rounds++;
         delta = (guess >= prev) ? guess - prev : prev - guess;
         if (delta <= {48'b0, tolerance}) begin
            converged = 1'b1;
         end
      end
      result.root        = (guess > {40'b0, bsr_pkg::ROOT_MAX}) ? bsr_pkg::ROOT_MAX
                                                                : guess[bsr_pkg::ROOT_W-1:0];
      result.rounds_used = (rounds > bsr_pkg::ROUNDS_MAX) ? bsr_pkg::ROUNDS_MAX
                                                          : rounds[bsr_pkg::ROUNDS_W-1:0];
      result.cap_hit     = !converged;
      return result;
   endfunction

   function void note_request(input logic [bsr_pkg::RAD_W-1:0] radicand);
      pending_roots.push_back(predict_root(radicand));
   endfunction

   function void check_result(input root_result_type actual);
      root_result_type expected;
      if (pending_roots.size() == 0) begin
         $display("%0t: result with no request pending: root %h rounds %0d cap %b",
                  $time, actual.root, actual.rounds_used, actual.cap_hit);
         mismatches++;
         return;
      end
      expected = pending_roots.pop_front();
      if (actual.root !== expected.root) begin
         $display("%0t: root expected %h actual %h", $time, expected.root, actual.root);
         mismatches++;
      end
      if (actual.rounds_used !== expected.rounds_used) begin
         $display("%0t: rounds_used expected %0d actual %0d",
                  $time, expected.rounds_used, actual.rounds_used);
         mismatches++;
      end
      if (actual.cap_hit !== expected.cap_hit) begin
         $display("%0t: cap_hit expected %b actual %b",
                  $time, expected.cap_hit, actual.cap_hit);
         mismatches++;
      end
   endfunction
endclass

module testbench;

   localparam int unsigned CYCLE_LIMIT = 10_000_000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [bsr_pkg::RAD_W-1:0]        req_radicand = '0;
   logic                             rsp_valid;
   logic [bsr_pkg::ROOT_W-1:0]       rsp_root;
   logic [bsr_pkg::ROUNDS_W-1:0]     rsp_rounds_used;
   logic                             rsp_cap_hit;
   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [bsr_pkg::ADDR_W-1:0]       paddr = '0;
   logic [bsr_pkg::APB_W-1:0]        pwdata = '0;
   logic [bsr_pkg::APB_W-1:0]        prdata;
   logic                             pready;

   root_scoreboard sb = new();
   int unsigned    cycle_count = 0;
   bit             steady = 1'b0;

   babylonian_square_root u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_radicand    (req_radicand),
      .rsp_valid       (rsp_valid),
      .rsp_root        (rsp_root),
      .rsp_rounds_used (rsp_rounds_used),
      .rsp_cap_hit     (rsp_cap_hit),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[babylonian_square_root] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         sb.note_request(req_radicand);
      end
      if (!reset && rsp_valid) begin
         sb.check_result('{root: rsp_root, rounds_used: rsp_rounds_used,
                           cap_hit: rsp_cap_hit});
      end
   end

   function automatic logic [bsr_pkg::RAD_W-1:0] pick_radicand();
      int unsigned k;
      case ($urandom_range(0, 9))
         0: return 32'($urandom_range(0, 255));
         1: return 32'($urandom_range(0, 65535));
         2: begin
            k = $urandom_range(1, 255);
            return 32'(k * k) << bsr_pkg::FRAC_BITS;
         end
         3: return 32'hFFFF_0000 | 32'($urandom_range(0, 65535));
         4: return ($urandom_range(0, 3) == 0) ? '0 : $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [bsr_pkg::RAD_W-1:0] radicand);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_radicand <= radicand;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [bsr_pkg::TOL_W-1:0] value);
      drain();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= bsr_pkg::ADDR_TOLERANCE;
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_tolerance(value);
      @(posedge clock);
   endtask

   task automatic run_batch(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 48 == 0) begin
            steady = ($urandom_range(0, 3) == 0);
         end
         send_request(pick_radicand());
         if ($urandom_range(0, 99) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      logic [bsr_pkg::RAD_W-1:0] directed[$];
      directed = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                   32'h0000_0100, 32'h0000_FFFF, 32'h0001_0000, 32'h0002_0000,
                   32'h0004_0000, 32'h0010_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'hFFFF_FFFE,
                   32'hFFFF_FFFF};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_request(directed[i]);
      end
      drain();
      run_batch(150);

      write_tolerance(16'd1);
      run_batch(250);
      write_tolerance(16'hFFFF);
      send_request(32'hFFFF_FFFF);
      send_request(32'h0000_0001);
      run_batch(250);

      // A tolerance of zero lets integer oscillation run to the round cap.
      write_tolerance(16'd0);
      foreach (directed[i]) begin
         send_request(directed[i]);
      end
      run_batch(25);

      for (int phase = 0; phase < 3; phase++) begin
         write_tolerance((phase == 1) ? 16'($urandom_range(1, 16))
                                      : 16'($urandom_range(1, 65535)));
         run_batch(170);
      end

      drain();
      repeat (64) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[babylonian_square_root] OK");
      end else begin
         if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
         end
         $display("[babylonian_square_root] ERROR");
      end
      $finish;
   end

endmodule
